FILE: rtl/bdq_pkg.sv
// Package for the bounded double-ended queue: sizes, action codes, beat types
// and ring index helpers. It has no dependencies of its own.
package bdq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W = 7;
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 3;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK      = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
    logic [OUT_CNT_W-1:0]    entry_count;
  } bdq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic take_fetch;
  } bdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fetch;
  } bdq_status_t;

  function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

FILE: rtl/bdq_ctrl.sv
// Controller of the bounded double-ended queue: input and output handshakes,
// the fetch wait state and the output beat valid. Depends on bdq_pkg.
module bdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  bdq_pkg::bdq_status_t status_i,
  output bdq_pkg::bdq_cmd_t   cmd_o
);
  import bdq_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;
  logic   produce;

  // The output register can take a new beat when it is empty or drains now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd_o.take_item  = accept;
  assign cmd_o.take_fetch = (state_q == ST_FETCH) && out_free;

  assign produce = (accept && !status_i.need_fetch) || cmd_o.take_fetch;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && status_i.need_fetch) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || produce;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rise_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(accept) || $past(state_q == ST_FETCH)))
    else $error("output beat appeared without an item behind it");

  a_fetch_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.need_fetch) |=> (state_q == ST_FETCH))
    else $error("delete needing a ring read did not enter the fetch state");

  a_no_item_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> !cmd_o.take_item)
    else $error("item taken while a ring read is outstanding");

endmodule

FILE: rtl/bdq_datapath.sv
// Datapath of the bounded double-ended queue: ring memory, indices, count,
// capacity register, cached end values and the output beat. Depends on bdq_pkg.
module bdq_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bdq_pkg::bdq_in_t    in_item_i,
  input  logic                cfg_we_i,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_data_i,
  input  bdq_pkg::bdq_cmd_t   cmd_i,
  output bdq_pkg::bdq_status_t status_o,
  output bdq_pkg::bdq_out_t   out_beat_o
);
  import bdq_pkg::*;

  logic [VAL_W-1:0] ring_mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  logic [IDX_W-1:0] front_q, front_d, rear_q, rear_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic [VAL_W-1:0] fval_q, rval_q, fval_d, rval_d;
  logic             fetch_front_q;
  logic             fetch_front;
  bdq_out_t         out_q;

  logic [CMP_W-1:0] cap_eff;
  logic             full;
  logic             ok;
  logic             need_fetch;
  logic             ins_ok;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;

  // Post-beat values used for the cache and the output register.
  logic [CNT_W-1:0] count_n;
  logic [VAL_W-1:0] fval_n, rval_n;
  logic             ok_n;
  logic             load_out;

  assign cap_eff = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign full    = CMP_W'(count_q) >= cap_eff;

  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    count_d     = count_q;
    fval_d      = fval_q;
    rval_d      = rval_q;
    ok          = 1'b0;
    need_fetch  = 1'b0;
    fetch_front = 1'b0;
    ins_ok      = 1'b0;
    waddr       = front_q;
    raddr       = front_q;
    unique case (in_item_i.action)
      ACT_INS_FRONT: begin
        if (!full) begin
          ok      = 1'b1;
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
          fval_d  = in_item_i.value;
          if (count_q == '0) begin
            rear_d = front_q;
            rval_d = in_item_i.value;
          end else begin
            front_d = slot_prev(front_q);
            waddr   = slot_prev(front_q);
          end
        end
      end
      ACT_INS_REAR: begin
        if (!full) begin
          ok      = 1'b1;
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
          rval_d  = in_item_i.value;
          if (count_q == '0) begin
            rear_d = front_q;
            fval_d = in_item_i.value;
          end else begin
            rear_d = slot_next(rear_q);
            waddr  = slot_next(rear_q);
          end
        end
      end
      ACT_DEL_FRONT: begin
        if (count_q != '0) begin
          ok      = 1'b1;
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            rear_d = front_q;
          end else begin
            front_d     = slot_next(front_q);
            raddr       = slot_next(front_q);
            need_fetch  = 1'b1;
            fetch_front = 1'b1;
          end
        end
      end
      ACT_DEL_REAR: begin
        if (count_q != '0) begin
          ok      = 1'b1;
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            rear_d = front_q;
          end else begin
            rear_d     = slot_prev(rear_q);
            raddr      = slot_prev(rear_q);
            need_fetch = 1'b1;
          end
        end
      end
      ACT_PEEK: ok = 1'b1;
      default:  ok = 1'b0;
    endcase
  end

  assign status_o.need_fetch = need_fetch;

  // A fetch completes a delete whose indices and count were already committed.
  always_comb begin
    if (cmd_i.take_fetch) begin
      count_n = count_q;
      ok_n    = 1'b1;
      fval_n  = fetch_front_q ? rdata_q : fval_q;
      rval_n  = fetch_front_q ? rval_q : rdata_q;
    end else begin
      count_n = count_d;
      ok_n    = ok;
      fval_n  = fval_d;
      rval_n  = rval_d;
    end
  end

  assign load_out = (cmd_i.take_item && !need_fetch) || cmd_i.take_fetch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.take_item) begin
        front_q <= front_d;
        rear_q  <= rear_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item || cmd_i.take_fetch) begin
      fval_q <= fval_n;
      rval_q <= rval_n;
    end
    if (cmd_i.take_item) begin
      fetch_front_q <= fetch_front;
    end
    if (load_out) begin
      out_q.accepted    <= ok_n;
      out_q.front_value <= (count_n != '0) ? fval_n : '0;
      out_q.rear_value  <= (count_n != '0) ? rval_n : '0;
      out_q.is_empty    <= (count_n == '0);
      out_q.is_full     <= CMP_W'(count_n) >= cap_eff;
      out_q.entry_count <= OUT_CNT_W'(count_n);
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item && ins_ok) begin
      ring_mem[waddr] <= in_item_i.value;
    end
    if (cmd_i.take_item && need_fetch) begin
      rdata_q <= ring_mem[raddr];
    end
  end

  assign out_beat_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(DEPTH))
    else $error("entry count exceeds the ring depth");

  a_empty_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rear_q == front_q))
    else $error("empty deque with front and rear apart");

  a_span_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |->
      (((rear_q >= front_q) ? (int'(rear_q) - int'(front_q))
                            : (int'(rear_q) + int'(DEPTH) - int'(front_q)))
       == int'(count_q) - 1))
    else $error("front to rear span disagrees with the entry count");

endmodule

FILE: rtl/bounded_double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_datapath.
//
// A deque of signed 32-bit values held in a 64-entry ring with a single
// write port and a single registered read port. Inserts, peeks, refused
// actions and deletes that leave the deque empty take one cycle each, so
// such items can be accepted back to back. A delete that leaves entries
// behind takes two cycles, because the new front or rear value must be read
// from the ring through its registered read port. Each item yields one
// result beat from an output register. While that beat is stalled the input
// is stalled too, and the next item can be taken at the edge where the beat
// leaves. The capacity register is written through the cfg channel,
// which is always ready; write it only while the block is idle.
module bounded_double_ended_queue_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bdq_pkg::bdq_in_t          in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bdq_pkg::bdq_out_t         out_beat_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_data_i
);
  import bdq_pkg::*;

  bdq_cmd_t    cmd;
  bdq_status_t status;

  assign cfg_ready_o = 1'b1;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bdq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_beat_o (out_beat_o)
  );

endmodule
